// ===== hdl/dqu_pkg.sv =====
package dqu_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // small queue between the command front end and the execution back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_item;

endpackage

// ===== hdl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH entries.
//
// Command channel: a transaction is taken on a rising edge with start high and busy
// low. i_command selects push front, push back, pop front, pop back or query
// (unused codes act as query); i_push_value is used by pushes only.
// Result channel: exactly one result per transaction, shown for one cycle with
// o_result_strobe high: popped value (-1 if none), status (ok, pop on empty, push
// dropped because full), entry count, empty flag and the front and back values
// (-1 when empty). Results come out in command order.
// Path from the accepting edge to the strobe: command queue entry, execution finish state, result register.
// The execution unit takes a new transaction only once it is through with the last:
// it accesses the ring store, then folds in its registered read data.
// A two-entry command queue lets start be taken while an earlier one executes;
// busy is high while that queue is full.
// The receiver cannot stall; every strobe must be captured when it appears.
// Reset (synchronous, active low) empties the queue; the ring store contents are
// not cleared, and an entry read before being written never reaches a result.
module double_ended_queue_unit #(
    parameter int DEPTH = dqu_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dqu_pkg::CMD_W-1:0]          i_command,
    input  logic signed [dqu_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_result_strobe,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_popped_value,
    output logic [dqu_pkg::STATUS_W-1:0]       o_status,
    output logic [dqu_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                               o_is_empty,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_back_value
);

    import dqu_pkg::*;

    logic  item_valid;
    t_item item;
    logic  item_take;

    dqu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_busy       (busy),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    dqu_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_item_take     (item_take),
        .o_result_strobe (o_result_strobe),
        .o_popped_value  (o_popped_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_front_value   (o_front_value),
        .o_back_value    (o_back_value)
    );

`ifndef SYNTHESIS
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("results closer than the execution unit allows");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_is_empty) |->
            (o_front_value == NO_VALUE && o_back_value == NO_VALUE))
        else $error("empty queue reports an end value");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_status == ST_EMPTY) |->
            (o_is_empty && o_popped_value == NO_VALUE))
        else $error("pop on empty queue returned data or nonempty state");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_status == ST_FULL) |->
            (!o_is_empty && o_popped_value == NO_VALUE))
        else $error("dropped push reported inconsistent state");
`endif

endmodule

// ===== hdl/dqu_ram.sv =====
module dqu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dqu_front.sv =====
module dqu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [dqu_pkg::CMD_W-1:0]          i_command,
    input  logic signed [dqu_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_busy,
    output logic                               o_item_valid,
    output dqu_pkg::t_item                     o_item,
    input  logic                               i_item_take
);

    import dqu_pkg::*;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_fill, n_fill;
    logic              accept;
    logic              take;
    t_item             item_in;

    always_comb begin
        item_in.value = i_push_value;
        unique case (i_command)
            CMD_PUSH_FRONT: item_in.op = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  item_in.op = OP_PUSH_BACK;
            CMD_POP_FRONT:  item_in.op = OP_POP_FRONT;
            CMD_POP_BACK:   item_in.op = OP_POP_BACK;
            default:        item_in.op = OP_QUERY;   // query and unused codes
        endcase
    end

    assign o_busy       = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign accept       = i_start && !o_busy;
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign take         = i_item_take && o_item_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (take) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_fill = r_fill + QCNT_W'(accept) - QCNT_W'(take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

endmodule

// ===== hdl/dqu_back.sv =====
module dqu_back #(
    parameter int DEPTH = dqu_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  dqu_pkg::t_item                     i_item,
    output logic                               o_item_take,
    output logic                               o_result_strobe,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_popped_value,
    output logic [dqu_pkg::STATUS_W-1:0]       o_status,
    output logic [dqu_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                               o_is_empty,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [dqu_pkg::DATA_W-1:0]  o_back_value
);

    import dqu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0]         r_front_ptr, n_front_ptr;
    logic [PTR_W-1:0]         r_back_ptr, n_back_ptr;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_front_val, n_front_val;
    logic signed [DATA_W-1:0] r_back_val, n_back_val;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic                     r_refresh_front, n_refresh_front;
    logic                     r_refresh_back, n_refresh_back;

    logic                     r_res_valid;
    logic signed [DATA_W-1:0] r_res_popped;
    logic [STATUS_W-1:0]      r_res_status;
    logic [COUNT_W-1:0]       r_res_count;
    logic                     r_res_empty;
    logic signed [DATA_W-1:0] r_res_front;
    logic signed [DATA_W-1:0] r_res_back;

    logic                     ram_we;
    logic [PTR_W-1:0]         ram_waddr;
    logic [PTR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     is_full;
    logic                     is_zero;
    logic [PTR_W-1:0]         back_dec;
    logic signed [DATA_W-1:0] fin_front;
    logic signed [DATA_W-1:0] fin_back;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    dqu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_zero  = (r_count == '0);
    assign back_dec = ptr_dec(r_back_ptr);

    assign o_item_take = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_front_ptr     = r_front_ptr;
        n_back_ptr      = r_back_ptr;
        n_count         = r_count;
        n_front_val     = r_front_val;
        n_back_val      = r_back_val;
        n_popped        = r_popped;
        n_status        = r_status;
        n_refresh_front = r_refresh_front;
        n_refresh_back  = r_refresh_back;
        ram_we          = 1'b0;
        ram_waddr       = r_back_ptr;
        ram_raddr       = r_front_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state         = S_FINISH;
                    n_popped        = NO_VALUE;
                    n_status        = ST_OK;
                    n_refresh_front = 1'b0;
                    n_refresh_back  = 1'b0;
                    unique case (i_item.op)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front_ptr = ptr_dec(r_front_ptr);
                                ram_we      = 1'b1;
                                ram_waddr   = n_front_ptr;
                                n_front_val = i_item.value;
                                if (is_zero) begin
                                    n_back_val = i_item.value;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = r_back_ptr;
                                n_back_ptr = ptr_inc(r_back_ptr);
                                n_back_val = i_item.value;
                                if (is_zero) begin
                                    n_front_val = i_item.value;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_zero) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped        = r_front_val;
                                n_front_ptr     = ptr_inc(r_front_ptr);
                                ram_raddr       = n_front_ptr;
                                n_refresh_front = 1'b1;
                                n_count         = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_zero) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped       = r_back_val;
                                n_back_ptr     = back_dec;
                                ram_raddr      = ptr_dec(back_dec);
                                n_refresh_back = 1'b1;
                                n_count        = r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FINISH: begin
                // store read data lands now; fold it into the cached ends
                n_state     = S_IDLE;
                n_front_val = fin_front;
                n_back_val  = fin_back;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign fin_front = r_refresh_front ? $signed(ram_rdata) : r_front_val;
    assign fin_back  = r_refresh_back  ? $signed(ram_rdata) : r_back_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_ptr <= '0;
            r_back_ptr  <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front_ptr <= n_front_ptr;
            r_back_ptr  <= n_back_ptr;
            r_count     <= n_count;
            r_res_valid <= (r_state == S_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val     <= n_front_val;
        r_back_val      <= n_back_val;
        r_popped        <= n_popped;
        r_status        <= n_status;
        r_refresh_front <= n_refresh_front;
        r_refresh_back  <= n_refresh_back;
        if (r_state == S_FINISH) begin
            r_res_popped <= r_popped;
            r_res_status <= r_status;
            r_res_count  <= COUNT_W'(r_count);
            r_res_empty  <= is_zero;
            r_res_front  <= is_zero ? NO_VALUE : fin_front;
            r_res_back   <= is_zero ? NO_VALUE : fin_back;
        end
    end

    assign o_result_strobe = r_res_valid;
    assign o_popped_value  = r_res_popped;
    assign o_status        = r_res_status;
    assign o_entry_count   = r_res_count;
    assign o_is_empty      = r_res_empty;
    assign o_front_value   = r_res_front;
    assign o_back_value    = r_res_back;

endmodule

// ===== tb/sv/tb_double_ended_queue_unit.sv =====
module tb_double_ended_queue_unit;

    import dqu_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
    } t_deque_result;

    typedef enum {MIX_WALK, FILL_WALK, DRAIN_WALK} t_walk;

    class t_deque_scoreboard;
        logic signed [DATA_W-1:0] ring [DEPTH];
        int unsigned              head;
        int unsigned              tail;
        int unsigned              fill;
        t_deque_result            outstanding[$];
        int                       mismatches;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            mismatches = 0;
        endfunction

        function string show(t_deque_result r);
            return $sformatf("pop=%0d st=%0d cnt=%0d emp=%0b front=%0d back=%0d",
                             r.popped, r.status, r.count, r.empty, r.front, r.back);
        endfunction

        function void flag_error(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", what);
        endfunction

        // one accepted command -> one expected result
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
            t_deque_result r;
            r.popped = NO_VALUE;
            r.status = ST_OK;
            r.front  = NO_VALUE;
            r.back   = NO_VALUE;
            case (cmd)
                CMD_PUSH_FRONT: begin
                    if (fill == DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        fill++;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (fill == DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ring[tail] = val;
                        tail = (tail + 1) % DEPTH;
                        fill++;
                    end
                end
                CMD_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = ring[head];
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                CMD_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        tail = (tail + DEPTH - 1) % DEPTH;
                        r.popped = ring[tail];
                        fill--;
                    end
                end
                default: ;  // query and unused codes leave the ring alone
            endcase
            if (fill != 0) begin
                r.front = ring[head];
                r.back  = ring[(tail + DEPTH - 1) % DEPTH];
            end
            r.count = COUNT_W'(fill);
            r.empty = (fill == 0);
            outstanding.insert(outstanding.size(), r);
        endfunction

        function void check_result(t_deque_result got);
            t_deque_result want;
            if (outstanding.size() == 0) begin
                flag_error({"result with no transaction outstanding: ", show(got)});
            end else begin
                want = outstanding[0];
                outstanding.delete(0);
                if (got !== want)
                    flag_error({"exp ", show(want), " | got ", show(got)});
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_command = CMD_QUERY;
    logic signed [DATA_W-1:0]  i_push_value = '0;
    logic                      o_result_strobe;
    logic signed [DATA_W-1:0]  o_popped_value;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_entry_count;
    logic                      o_is_empty;
    logic signed [DATA_W-1:0]  o_front_value;
    logic signed [DATA_W-1:0]  o_back_value;

    t_deque_scoreboard sb = new();
    bit                idle_on = 1'b1;
    int                quiet_cycles = 0;

    double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_push_value    (i_push_value),
        .o_result_strobe (o_result_strobe),
        .o_popped_value  (o_popped_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_front_value   (o_front_value),
        .o_back_value    (o_back_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            sb.check_result('{o_popped_value, o_status, o_entry_count, o_is_empty,
                              o_front_value, o_back_value});
    end

    // counts cycles where neither channel moves a transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
        while (idle_on && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, val);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.outstanding.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(t_walk walk);
        int unsigned roll;
        logic [CMD_W-1:0] push_cmd;
        logic [CMD_W-1:0] pop_cmd;
        logic [CMD_W-1:0] other_cmd;
        roll      = $urandom_range(0, 99);
        push_cmd  = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        pop_cmd   = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        other_cmd = $urandom_range(0, 1) ? CMD_QUERY
                  : CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        case (walk)
            FILL_WALK:  return (roll < 95) ? push_cmd : other_cmd;
            DRAIN_WALK: return (roll < 75) ? pop_cmd : (roll < 90) ? push_cmd : other_cmd;
            default:    return (roll < 42) ? push_cmd : (roll < 88) ? pop_cmd : other_cmd;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return NO_VALUE;
            endcase
        end
        return $urandom;
    endfunction

    task automatic run_walk(input t_walk walk, input int n);
        repeat (n) issue(pick_command(walk), pick_value());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: query, pops on empty, unused codes
        issue(CMD_QUERY, VAL_MAX);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_UNUSED_FIRST, VAL_MIN);
        issue(CMD_UNUSED_MID, NO_VALUE);
        issue(CMD_UNUSED_LAST, VAL_MAX);
        // front push wraps the front pointer below zero
        issue(CMD_PUSH_FRONT, VAL_MAX);
        issue(CMD_PUSH_BACK, VAL_MIN);
        issue(CMD_PUSH_FRONT, NO_VALUE);
        issue(CMD_PUSH_BACK, '0);
        issue(CMD_QUERY, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_FRONT, '0);
        // single entry seen at both ends
        issue(CMD_PUSH_BACK, 32'sh1234_5678);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_PUSH_FRONT, 32'sh5555_5555);
        issue(CMD_POP_BACK, '0);
        issue(CMD_PUSH_BACK, 32'shAAAA_AAAA);
        issue(CMD_POP_BACK, '0);
        wait_drained();

        run_walk(MIX_WALK, 300);
        wait_drained();

        // long burst without gaps until the ring is full, then churn at the top
        idle_on = 1'b0;
        while (sb.fill < DEPTH)
            issue(pick_command(FILL_WALK), pick_value());
        run_walk(FILL_WALK, 10);
        idle_on = 1'b1;
        run_walk(MIX_WALK, 150);
        wait_drained();

        run_walk(DRAIN_WALK, 250);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dqu_pkg.sv
hdl/dqu_ram.sv
hdl/dqu_front.sv
hdl/dqu_back.sv
hdl/double_ended_queue_unit.sv
tb/sv/tb_double_ended_queue_unit.sv
